// File: hw/rtl/rls_pkg.sv
// shared types and constants of the rms level smoother
package rls_pkg;

    // frame limit per buffer and derived widths
    localparam int MAX_FRAMES = 1024;
    localparam int SAMPLE_W   = 16;
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int DIV_W      = CNT_W + 1;
    localparam int SUM_W      = 40;
    localparam int ROOT_W     = 15;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = (DIV_W + 1 > ROOT_W + 4) ? DIV_W + 1 : ROOT_W + 4;
    localparam int ITER_W     = $clog2(SUM_W);
    localparam int SQ_W       = 2 * (SAMPLE_W - 1) - 1;
    localparam int MUL_W      = 18;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int LVL_ACC_W  = 32;
    localparam int FRAC_W     = 16;

    // smoothing factors 0.93 and 0.07 in q0.16
    localparam logic signed [MUL_W-1:0] KEEP_Q16 = 18'sd60948;
    localparam logic signed [MUL_W-1:0] TAKE_Q16 = 18'sd4588;

    // tdata widths, padded to whole bytes
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_L,
        ST_SQ_R,
        ST_ADD,
        ST_PREP,
        ST_DIV,
        ST_SQRT,
        ST_SM_A,
        ST_SM_B,
        ST_SM_C,
        ST_OUT
    } rls_state_t;

endpackage

// File: hw/rtl/rms_level_smoother_top.sv
// rms level smoother: sum of squares, iterative divide and square root, smoothing
//
// channel   dir  tdata (low bit up)                       tuser  tlast
// s_axis    in   left_sample[15:0], right_sample[31:16]    -      last_frame
// m_axis    out  buffer_rms[14:0], smoothed_level[29:15]   -      -
//
// an ordinary frame runs from its beat to the next beat through two squares on the single
// 18x18 multiplier and two saturating adds into the sum
// a frame marked last then runs 40 restoring divide steps and 15 square root steps that
// share one subtract-compare unit, then smoothing on the multiplier
// s_axis_tready is high only while the sequencer is idle; a waiting result does not block
// input, but a new result waits in its final state until the output register is free
// reset is synchronous on aresetn low and clears the sum, frame count and smoothed level
module rms_level_smoother_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [rls_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // left_sample, right_sample
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rls_pkg::M_TDATA_W-1:0]    m_axis_tdata   // buffer_rms, smoothed_level, pad
);
    import rls_pkg::*;

    rls_state_t state_reg, state_next;

    logic signed [SAMPLE_W-1:0] left_reg, left_next;
    logic signed [SAMPLE_W-1:0] right_reg, right_next;
    logic                       last_reg, last_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [ROOT_W-1:0]          level_reg, level_next;
    logic [ROOT_W-1:0]          root_reg, root_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [ITER_W-1:0]          iter_reg, iter_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic [LVL_ACC_W-1:0]       acc_reg, acc_next;
    logic                       m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]       m_data_reg, m_data_next;

    // shared multiplier operands
    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    // shared subtract-compare unit
    logic [REM_W-1:0]           sub_a, sub_b;
    logic [REM_W:0]             sub_d;
    logic                       sub_ge;
    // saturating accumulate of one square
    logic [SUM_W:0]             sum_add;
    logic [SUM_W-1:0]           sum_sat;
    logic [LVL_ACC_W:0]         lvl_sum;
    logic signed [SAMPLE_W-1:0] half_l, half_r;
    logic                       not_full;

    // halved samples, arithmetic shift
    assign half_l   = left_reg >>> 1;
    assign half_r   = right_reg >>> 1;
    assign not_full = count_reg < CNT_W'(MAX_FRAMES);

    // operand selection for the multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQ_L: begin
                mul_a = MUL_W'(half_l);
                mul_b = MUL_W'(half_l);
            end
            ST_SQ_R: begin
                mul_a = MUL_W'(half_r);
                mul_b = MUL_W'(half_r);
            end
            ST_SM_A: begin
                mul_a = KEEP_Q16;
                mul_b = signed'(MUL_W'(level_reg));
            end
            ST_SM_B: begin
                mul_a = TAKE_Q16;
                mul_b = signed'(MUL_W'(root_reg));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // operand selection for the subtract-compare unit
    always_comb begin
        if (state_reg == ST_SQRT) begin
            sub_a = {rem_reg[REM_W-3:0], sum_reg[RAD_W-1 -: 2]};
            sub_b = REM_W'({root_reg, 2'b01});
        end else begin
            sub_a = {rem_reg[REM_W-2:0], sum_reg[SUM_W-1]};
            sub_b = REM_W'({count_reg, 1'b0});
        end
    end

    assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge = !sub_d[REM_W];

    // sum plus latest square, saturating
    assign sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(prod_reg[SQ_W-1:0]);
    assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

    // weighted sum of old level and new rms
    assign lvl_sum = {1'b0, acc_reg} + {1'b0, prod_reg[LVL_ACC_W-1:0]};

    // sequencer: next state and datapath updates
    always_comb begin
        state_next   = state_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        last_next    = last_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        level_next   = level_reg;
        root_next    = root_reg;
        rem_next     = rem_reg;
        iter_next    = iter_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        s_axis_tready = 1'b0;

        // output register drains independently
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    left_next  = s_axis_tdata[SAMPLE_W-1:0];
                    right_next = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
                    last_next  = s_axis_tlast;
                    state_next = ST_SQ_L;
                end
            end
            ST_SQ_L: begin
                prod_next = mul_p;
                if (not_full) begin
                    state_next = ST_SQ_R;
                end else if (last_reg) begin
                    state_next = ST_PREP;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SQ_R: begin
                sum_next   = sum_sat;
                prod_next  = mul_p;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                sum_next   = sum_sat;
                count_next = count_reg + 1'b1;
                state_next = last_reg ? ST_PREP : ST_IDLE;
            end
            ST_PREP: begin
                rem_next  = '0;
                iter_next = '0;
                root_next = '0;
                // empty buffer gives a zero mean
                if (count_reg == '0) begin
                    sum_next   = '0;
                    state_next = ST_SQRT;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next = sub_ge ? sub_d[REM_W-1:0] : sub_a;
                sum_next = {sum_reg[SUM_W-2:0], sub_ge};
                if (iter_reg == ITER_W'(SUM_W - 1)) begin
                    rem_next   = '0;
                    iter_next  = '0;
                    state_next = ST_SQRT;
                end else begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            ST_SQRT: begin
                rem_next  = sub_ge ? sub_d[REM_W-1:0] : sub_a;
                sum_next  = {sum_reg[SUM_W-3:0], 2'b00};
                root_next = {root_reg[ROOT_W-2:0], sub_ge};
                if (iter_reg == ITER_W'(ROOT_W - 1)) begin
                    state_next = ST_SM_A;
                end else begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            ST_SM_A: begin
                prod_next  = mul_p;
                state_next = ST_SM_B;
            end
            ST_SM_B: begin
                acc_next   = prod_reg[LVL_ACC_W-1:0];
                prod_next  = mul_p;
                state_next = ST_SM_C;
            end
            ST_SM_C: begin
                level_next = lvl_sum[FRAC_W +: ROOT_W];
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_W'({level_reg, root_reg});
                    sum_next     = '0;
                    count_next   = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // control and accumulated state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            count_reg   <= '0;
            level_reg   <= '0;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            level_reg   <= level_next;
            iter_reg    <= iter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        left_reg   <= left_next;
        right_reg  <= right_next;
        last_reg   <= last_next;
        root_reg   <= root_next;
        rem_reg    <= rem_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // frame count never passes the per-buffer limit
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_FRAMES))
        else $error("frame count above limit");

    // a result is only loaded from the output state
    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");

    // no second beat is taken while a frame is being worked on
    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready while busy");

    // rms and level stay within the q0.15 range
    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg[ROOT_W-1:0] <= ROOT_W'(16384))
                     && (m_data_reg[2*ROOT_W-1:ROOT_W] <= ROOT_W'(16384)))
        else $error("result out of range");

endmodule

// File: tb/rms_meter_checker.sv
// checker for the rms level smoother: predicts buffer rms and smoothed level, compares results
`timescale 1ns / 1ps

module rms_meter_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // left_sample, right_sample
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // buffer_rms, smoothed_level, pad
    output int          mismatch_count,
    output int          results_pending
);

    import rls_pkg::*;

    // q0.16 smoothing weights and the ceiling of the square sum
    localparam longint unsigned KEEP_WEIGHT = 60948;
    localparam longint unsigned TAKE_WEIGHT = 4588;
    localparam longint unsigned SUM_CEILING = (64'd1 << SUM_W) - 1;

    typedef struct packed {
        logic [ROOT_W-1:0] rms;
        logic [ROOT_W-1:0] level;
    } level_pair_t;

    level_pair_t       expected_levels[$];
    level_pair_t       want;
    level_pair_t       got;
    longint unsigned   sum_of_squares;
    longint unsigned   sum_next;
    longint unsigned   frames_held;
    longint unsigned   mean_square;
    longint unsigned   level_next;
    logic [ROOT_W-1:0] smoothed;
    logic [ROOT_W-1:0] rms_now;

    // square of a sample after an arithmetic halving
    function automatic longint unsigned halved_square(logic signed [SAMPLE_W-1:0] s);
        logic signed [SAMPLE_W-2:0] h;
        longint                     hv;
        h  = (SAMPLE_W-1)'(s >>> 1);
        hv = h;
        return hv * hv;
    endfunction

    // integer square root, largest root whose square does not exceed x
    function automatic logic [ROOT_W-1:0] floor_root(longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 20; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root[ROOT_W-1:0];
    endfunction

    // compare outgoing beats first, then fold in the accepted frame
    always @(posedge aclk) begin
        if (!aresetn) begin
            sum_of_squares = 0;
            frames_held    = 0;
            smoothed       = '0;
            expected_levels.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.rms   = m_axis_tdata[ROOT_W-1:0];
                got.level = m_axis_tdata[2*ROOT_W-1:ROOT_W];
                if (expected_levels.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result: rms %0d level %0d", got.rms, got.level);
                    mismatch_count++;
                end else begin
                    want = expected_levels.pop_front();
                    if (got.rms !== want.rms || got.level !== want.level) begin
                        if (mismatch_count < 10)
                            $display("mismatch: rms exp %0d got %0d, level exp %0d got %0d",
                                     want.rms, got.rms, want.level, got.level);
                        mismatch_count++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                // frames past the limit are dropped, but a last mark still closes the buffer
                if (frames_held < MAX_FRAMES) begin
                    sum_next = sum_of_squares
                             + halved_square(s_axis_tdata[SAMPLE_W-1:0])
                             + halved_square(s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]);
                    sum_of_squares = (sum_next > SUM_CEILING) ? SUM_CEILING : sum_next;
                    frames_held++;
                end
                if (s_axis_tlast) begin
                    mean_square = (frames_held != 0) ? sum_of_squares / (2 * frames_held) : 0;
                    rms_now     = floor_root(mean_square);
                    level_next  = (KEEP_WEIGHT * smoothed + TAKE_WEIGHT * rms_now) >> 16;
                    smoothed    = level_next[ROOT_W-1:0];
                    want.rms    = rms_now;
                    want.level  = smoothed;
                    expected_levels = {expected_levels, want};
                    sum_of_squares = 0;
                    frames_held    = 0;
                end
            end
        end
        results_pending = expected_levels.size();
    end

endmodule

// File: tb/tb_rms_level_smoother_top.sv
// testbench top for the rms level smoother: clock, reset, frame stimulus and verdict
`timescale 1ns / 1ps

module tb_rms_level_smoother_top;

    import rls_pkg::*;

    localparam int HOLD_CYCLES  = 500;
    localparam int PHASE_FRAMES = 95;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;     // left_sample, right_sample
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // buffer_rms, smoothed_level, pad

    int mismatch_count;
    int results_pending;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int holds_asked   = 0;
    int holds_done    = 0;
    int frames_sent   = 0;

    rms_level_smoother_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rms_meter_checker level_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // 2 ns clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    // hard stop if the run hangs
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // result side: random stalls, plus a long hold-off when one is asked for
    initial begin
        forever begin
            @(negedge aclk);
            if (holds_done != holds_asked) begin
                m_axis_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(negedge aclk);
                holds_done++;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // mix of full-range, small, extreme and large-magnitude samples
    function automatic logic [15:0] pick_sample();
        int v;
        case ($urandom_range(3))
            0: return 16'($urandom());
            1: begin
                v = $urandom_range(15);
                v = v - 8;
                return v[15:0];
            end
            2: case ($urandom_range(4))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'hFFFF;
                3: return 16'h0001;
                default: return 16'h0000;
            endcase
            default: return {($urandom_range(1) != 0) ? 2'b10 : 2'b01, 14'($urandom())};
        endcase
    endfunction

    // offer one frame beat after a random gap, called and returning at a falling edge
    task automatic push_frame(input logic [15:0] left, input logic [15:0] right,
                              input logic last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right, left};
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        frames_sent++;
        @(negedge aclk);
    endtask

    task automatic send_buffer(input int frames);
        for (int i = 1; i <= frames; i++)
            push_frame(pick_sample(), pick_sample(), i == frames);
    endtask

    // random buffers until the frame budget of this phase is used up
    task automatic random_buffers(input int budget);
        int stop_at;
        stop_at = frames_sent + budget;
        while (frames_sent < stop_at) begin
            if ($urandom_range(99) < 75)
                send_buffer($urandom_range(12, 1));
            else
                send_buffer($urandom_range(48, 13));
        end
    endtask

    initial begin
        // synchronous reset, held low from the start and released at a falling edge
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // single-frame buffers at the sample extremes
        push_frame(16'h0000, 16'h0000, 1'b1);
        push_frame(16'h8000, 16'h8000, 1'b1);
        push_frame(16'h7FFF, 16'h7FFF, 1'b1);
        push_frame(16'hFFFF, 16'hFFFF, 1'b1);
        push_frame(16'h0001, 16'h0001, 1'b1);
        push_frame(16'h8000, 16'h7FFF, 1'b1);
        // two and four frame buffers with mixed signs
        push_frame(16'h8000, 16'h0000, 1'b0);
        push_frame(16'h0000, 16'h7FFF, 1'b1);
        push_frame(16'h1234, 16'hEDCC, 1'b0);
        push_frame(16'hFFFE, 16'h0002, 1'b0);
        push_frame(16'h4000, 16'hC000, 1'b0);
        push_frame(16'h0003, 16'hFFFD, 1'b1);
        // full-scale buffers to drive the smoothed level upward
        for (int i = 0; i < 8; i++)
            push_frame(16'h8000, 16'h8000, 1'b1);

        // overlong buffer at full scale, last mark on a dropped frame
        for (int i = 1; i <= MAX_FRAMES + 6; i++)
            push_frame(16'h8000, 16'h8000, i == MAX_FRAMES + 6);

        // phase without idling, with a long result hold-off while frames keep coming
        holds_asked++;
        for (int i = 0; i < 5; i++)
            send_buffer(2);
        s_axis_tvalid <= 1'b0;
        wait (results_pending == 0);
        @(negedge aclk);
        random_buffers(PHASE_FRAMES);

        // sender gaps only
        send_idle_pct = 56;
        stall_pct     = 0;
        random_buffers(PHASE_FRAMES);

        // receiver stalls only
        send_idle_pct = 0;
        stall_pct     = 56;
        random_buffers(PHASE_FRAMES);

        // both sides idle
        send_idle_pct = 25;
        stall_pct     = 25;
        random_buffers(PHASE_FRAMES);

        // drain and give the verdict
        s_axis_tvalid <= 1'b0;
        wait (results_pending == 0);
        repeat (80) @(posedge aclk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
